// ===== rtl/core/block_biquad_iir_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Biquad filter assertion macros
// Shared property forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BIQUAD_IIR_FILTER_MACROS_SVH
`define BLOCK_BIQUAD_IIR_FILTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BQF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BQF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bqf_pkg.sv =====
// ----------------------------------------------------------------------------
// Biquad filter package
// Widths, fixed-point constants, register indexes and shared types.
// ----------------------------------------------------------------------------
package bqf_pkg;

    localparam int LANES     = 8;
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 32;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int FRAC_BITS = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_B0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_B1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_B2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_A1 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = CFG_IDX_W'(4);

    localparam logic signed [ACC_W-1:0] ACC_ROUND  = ACC_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] ACC_SAT_HI = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] ACC_SAT_LO = ACC_W'(-8388608);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef_val;
    typedef logic signed [PROD_W-1:0]   t_prod;

    typedef struct packed {
        t_coef_val b0;
        t_coef_val b1;
        t_coef_val b2;
        t_coef_val a1;
        t_coef_val a2;
    } t_coef;

    typedef struct packed {
        t_sample x1;
        t_sample x2;
        t_sample y1;
        t_sample y2;
    } t_hist;

    // request handed from one cell to the next: go pulse plus delay line
    typedef struct packed {
        logic  go;
        t_hist hist;
    } t_link;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

// ===== rtl/core/bqf_cell.sv =====
// ----------------------------------------------------------------------------
// Biquad lane cell
// Holds one lane's sample and result; runs one filter step when the delay
// line arrives and hands the advanced delay line to the next cell.
// ----------------------------------------------------------------------------
module bqf_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  bqf_pkg::t_sample i_sample,
    input  bqf_pkg::t_coef   i_coef,
    input  bqf_pkg::t_link   i_link,
    output bqf_pkg::t_link   o_link,
    output bqf_pkg::t_sample o_y
);

    logic             r_busy;
    logic             r_done;
    bqf_pkg::t_sample r_x;
    bqf_pkg::t_sample r_y;
    bqf_pkg::t_hist   r_hist;
    bqf_pkg::t_hist   r_hand;
    bqf_pkg::t_prod   r_p_b0;
    bqf_pkg::t_prod   r_p_b1;
    bqf_pkg::t_prod   r_p_b2;
    bqf_pkg::t_prod   r_p_a1;
    bqf_pkg::t_prod   r_p_a2;

    logic signed [bqf_pkg::ACC_W-1:0] w_acc;
    logic signed [bqf_pkg::ACC_W-1:0] w_q;
    bqf_pkg::t_sample                 w_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_link.go;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_sample;
            r_y <= '0;
        end
        if (i_link.go) begin
            r_hist <= i_link.hist;
            r_p_b0 <= bqf_pkg::PROD_W'(r_x) * bqf_pkg::PROD_W'(i_coef.b0);
            r_p_b1 <= bqf_pkg::PROD_W'(i_link.hist.x1) * bqf_pkg::PROD_W'(i_coef.b1);
            r_p_b2 <= bqf_pkg::PROD_W'(i_link.hist.x2) * bqf_pkg::PROD_W'(i_coef.b2);
            r_p_a1 <= bqf_pkg::PROD_W'(i_link.hist.y1) * bqf_pkg::PROD_W'(i_coef.a1);
            r_p_a2 <= bqf_pkg::PROD_W'(i_link.hist.y2) * bqf_pkg::PROD_W'(i_coef.a2);
        end
        if (r_busy) begin
            r_y         <= w_y;
            r_hand.x1   <= r_x;
            r_hand.x2   <= r_hist.x1;
            r_hand.y1   <= w_y;
            r_hand.y2   <= r_hist.y1;
        end
    end

    // sum, round half up, floor shift, clamp to Q1.23
    always_comb begin
        w_acc = bqf_pkg::ACC_W'(r_p_b0) + bqf_pkg::ACC_W'(r_p_b1) + bqf_pkg::ACC_W'(r_p_b2)
              - bqf_pkg::ACC_W'(r_p_a1) - bqf_pkg::ACC_W'(r_p_a2) + bqf_pkg::ACC_ROUND;
        w_q   = w_acc >>> bqf_pkg::FRAC_BITS;
        if (w_q > bqf_pkg::ACC_SAT_HI) begin
            w_y = bqf_pkg::ACC_SAT_HI[bqf_pkg::SAMPLE_W-1:0];
        end else if (w_q < bqf_pkg::ACC_SAT_LO) begin
            w_y = bqf_pkg::ACC_SAT_LO[bqf_pkg::SAMPLE_W-1:0];
        end else begin
            w_y = w_q[bqf_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_link.go   = r_done;
    assign o_link.hist = r_hand;
    assign o_y         = r_y;

endmodule

// ===== rtl/core/block_biquad_iir_filter.sv =====
// ----------------------------------------------------------------------------
// Block biquad IIR filter
// Direct form I biquad over blocks of eight Q1.23 samples, one lane cell each.
//
//   channel   direction  handshake               payload
//   input     in         i_valid / o_stall        i_sample_in_0..7, i_valid_count
//   output    out        o_valid / i_stall        o_sample_out_0..7, o_out_count
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each lane cell registers its five products, then sums and clamps them
// into its result and the advanced delay line, and the delay line walks
// the chain one lane after the other.
// The next item is taken in the cycle after the result moves to the output
// register; a stalled result holds in the cells until that register frees.
// Synchronous active-low reset clears coefficients, delay line and control.
// ----------------------------------------------------------------------------
module block_biquad_iir_filter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  i_sample_in_0,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  i_sample_in_1,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  i_sample_in_2,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  i_sample_in_3,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  i_sample_in_4,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  i_sample_in_5,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  i_sample_in_6,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  i_sample_in_7,
    input  logic        [bqf_pkg::CNT_W-1:0]     i_valid_count,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [bqf_pkg::SAMPLE_W-1:0]  o_sample_out_0,
    output logic signed [bqf_pkg::SAMPLE_W-1:0]  o_sample_out_1,
    output logic signed [bqf_pkg::SAMPLE_W-1:0]  o_sample_out_2,
    output logic signed [bqf_pkg::SAMPLE_W-1:0]  o_sample_out_3,
    output logic signed [bqf_pkg::SAMPLE_W-1:0]  o_sample_out_4,
    output logic signed [bqf_pkg::SAMPLE_W-1:0]  o_sample_out_5,
    output logic signed [bqf_pkg::SAMPLE_W-1:0]  o_sample_out_6,
    output logic signed [bqf_pkg::SAMPLE_W-1:0]  o_sample_out_7,
    output logic        [bqf_pkg::CNT_W-1:0]     o_out_count,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [bqf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [bqf_pkg::COEF_W-1:0]    i_cfg_data
);

    localparam int LANES = bqf_pkg::LANES;

    bqf_pkg::t_state r_state;
    bqf_pkg::t_state n_state;

    bqf_pkg::t_coef              r_coef;
    bqf_pkg::t_hist              r_hist;
    logic [bqf_pkg::CNT_W-1:0]   r_count;
    logic                        r_out_valid;
    logic [bqf_pkg::CNT_W-1:0]   r_out_count;
    bqf_pkg::t_sample            r_out_y [LANES];

    bqf_pkg::t_sample            w_x       [LANES];
    bqf_pkg::t_sample            w_y       [LANES];
    bqf_pkg::t_link              w_link    [LANES+1];
    bqf_pkg::t_link              w_cell_in [LANES];
    logic [bqf_pkg::CNT_W-1:0]   w_cnt_sat;
    logic                        w_last_done;
    bqf_pkg::t_hist              w_last_hist;
    logic                        w_out_free;
    logic                        w_load;
    logic                        w_start;
    logic                        w_xfer;
    logic                        w_busy;

    assign w_x[0] = i_sample_in_0;
    assign w_x[1] = i_sample_in_1;
    assign w_x[2] = i_sample_in_2;
    assign w_x[3] = i_sample_in_3;
    assign w_x[4] = i_sample_in_4;
    assign w_x[5] = i_sample_in_5;
    assign w_x[6] = i_sample_in_6;
    assign w_x[7] = i_sample_in_7;

    assign w_cnt_sat  = (i_valid_count > bqf_pkg::CNT_W'(LANES))
                      ? bqf_pkg::CNT_W'(LANES) : i_valid_count;
    assign w_out_free = !r_out_valid || !i_stall;

    // lane chain: cells past the count never see the delay line
    assign w_link[0].go   = w_start;
    assign w_link[0].hist = r_hist;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        assign w_cell_in[k].go   = w_link[k].go && (bqf_pkg::CNT_W'(k) < r_count);
        assign w_cell_in[k].hist = w_link[k].hist;

        bqf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (w_load),
            .i_sample (w_x[k]),
            .i_coef   (r_coef),
            .i_link   (w_cell_in[k]),
            .o_link   (w_link[k+1]),
            .o_y      (w_y[k])
        );
    end

    always_comb begin
        w_last_done = 1'b0;
        w_last_hist = r_hist;
        for (int k = 0; k < LANES; k++) begin
            if (w_link[k+1].go && (bqf_pkg::CNT_W'(k + 1) == r_count)) begin
                w_last_done = 1'b1;
                w_last_hist = w_link[k+1].hist;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bqf_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (w_cnt_sat == '0) ? bqf_pkg::ST_DRAIN : bqf_pkg::ST_START;
                end
            end
            bqf_pkg::ST_START: begin
                n_state = bqf_pkg::ST_RUN;
            end
            bqf_pkg::ST_RUN: begin
                if (w_last_done) begin
                    n_state = w_out_free ? bqf_pkg::ST_IDLE : bqf_pkg::ST_DRAIN;
                end
            end
            bqf_pkg::ST_DRAIN: begin
                if (w_out_free) begin
                    n_state = bqf_pkg::ST_IDLE;
                end
            end
            default: n_state = bqf_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_busy  = 1'b1;
        w_load  = 1'b0;
        w_start = 1'b0;
        w_xfer  = 1'b0;
        case (r_state)
            bqf_pkg::ST_IDLE: begin
                w_busy = 1'b0;
                w_load = i_valid;
            end
            bqf_pkg::ST_START: begin
                w_start = 1'b1;
            end
            bqf_pkg::ST_RUN: begin
                w_xfer = w_last_done && w_out_free;
            end
            bqf_pkg::ST_DRAIN: begin
                w_xfer = w_out_free;
            end
            default: w_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bqf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_coef      <= '0;
            r_hist      <= '0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_count <= w_cnt_sat;
            end
            if (w_last_done) begin
                r_hist <= w_last_hist;
            end
            if (w_xfer) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bqf_pkg::CFG_B0: r_coef.b0 <= i_cfg_data;
                    bqf_pkg::CFG_B1: r_coef.b1 <= i_cfg_data;
                    bqf_pkg::CFG_B2: r_coef.b2 <= i_cfg_data;
                    bqf_pkg::CFG_A1: r_coef.a1 <= i_cfg_data;
                    bqf_pkg::CFG_A2: r_coef.a2 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_out_count <= r_count;
            for (int k = 0; k < LANES; k++) begin
                r_out_y[k] <= w_y[k];
            end
        end
    end

    assign o_stall        = w_busy;
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_out_count    = r_out_count;
    assign o_sample_out_0 = r_out_y[0];
    assign o_sample_out_1 = r_out_y[1];
    assign o_sample_out_2 = r_out_y[2];
    assign o_sample_out_3 = r_out_y[3];
    assign o_sample_out_4 = r_out_y[4];
    assign o_sample_out_5 = r_out_y[5];
    assign o_sample_out_6 = r_out_y[6];
    assign o_sample_out_7 = r_out_y[7];

endmodule

// ===== rtl/core/bqf_checker.sv =====
// ----------------------------------------------------------------------------
// Biquad filter port checker
// Watches the top-level ports for count, lane and handshake consistency.
// ----------------------------------------------------------------------------
`include "block_biquad_iir_filter_macros.svh"

module bqf_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_stall,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  o_sample_out_0,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  o_sample_out_7,
    input  logic        [bqf_pkg::CNT_W-1:0]     o_out_count
);

    localparam logic [bqf_pkg::CNT_W-1:0] FULL_CNT = bqf_pkg::CNT_W'(bqf_pkg::LANES);

    // reported count never exceeds the lane count
    `BQF_ASSERT_NOW(a_count_range, i_clk, i_rst_n, o_valid, o_out_count <= FULL_CNT, "count high")

    // last lane reads zero whenever the count leaves it unused
    `BQF_ASSERT_NOW(a_unused_zero, i_clk, i_rst_n, o_valid && (o_out_count < FULL_CNT), o_sample_out_7 == '0, "lane not zero")

    // one request at a time: an accepted item blocks the next cycle
    `BQF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "taken while busy")

    // a stalled result holds
    `BQF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_sample_out_0) && $stable(o_out_count), "result changed")

endmodule

bind block_biquad_iir_filter bqf_checker u_bqf_checker (.*);
